>>> rtl/sinv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sinv_pkg
// Types and constants shared by the sorted key table with nearest search.
// ----------------------------------------------------------------------------
package sinv_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 10;
    localparam int ENTRY_W     = KEY_W + TAG_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_FOUND    = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] key_value;
        logic [9:0]         record_tag;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] nearest_value;
        logic [9:0]         nearest_tag;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LB_RD,     // issue probe read of a binary search
        ST_LB_CMP,    // compare probe data
        ST_Q_RD1,     // read entry idx
        ST_Q_RD0,     // read entry idx-1, compare idx
        ST_Q_PICK,    // decide, start duplicate search
        ST_FETCH,     // read pick entry
        ST_FETCH_W,
        ST_SH_RD,     // read entry i-1 for shift
        ST_SH_WR,     // write entry i
        ST_INS_WR,
        ST_DONE
    } state_t;

    // what a lower/upper bound search feeds into when it ends
    typedef enum logic [1:0] {
        SRCH_INSERT,
        SRCH_QUERY,
        SRCH_DUP
    } srch_t;

endpackage
`default_nettype wire

>>> rtl/sinv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sinv_ram
// Single port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sinv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

>>> rtl/sorted_index_nearest_value_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_index_nearest_value_top
// Sorted (key, tag) table in one RAM with insertion sort and nearest search.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on result with done high for one cycle, and the receiver cannot
// stall it. All entries live in one single port RAM, so every step is one RAM
// access. An insert runs a binary search, then moves each entry behind the
// insert point up by one with a read and a write, so it takes longest when it
// lands at the front of the table. A query runs one binary search, or two in
// the worst case. A full or empty case answers without a RAM access.
// No clearing pass is needed after reset.
module sorted_index_nearest_value_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire sinv_pkg::cmd_t cmd,
    output logic                busy,
    output logic                done,
    output sinv_pkg::rsp_t      result
);

    localparam int AW = sinv_pkg::ADDR_W;
    localparam int CW = sinv_pkg::COUNT_W;

    sinv_pkg::state_t state_reg, state_next;
    sinv_pkg::srch_t  srch_reg, srch_next;
    sinv_pkg::cmd_t   cmd_reg, cmd_next;
    sinv_pkg::rsp_t   rsp_reg, rsp_next;
    logic             done_reg, done_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic signed [sinv_pkg::KEY_W-1:0] target_reg, target_next;
    logic signed [sinv_pkg::KEY_W-1:0] khi_reg, khi_next;
    logic          upper_reg, upper_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_addr;
    logic [sinv_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic signed [sinv_pkg::KEY_W-1:0] rd_key;
    logic [CW-1:0]               mid;
    logic signed [sinv_pkg::KEY_W:0] d_hi, d_lo;
    logic                        go_right;

    sinv_ram #(
        .WIDTH(sinv_pkg::ENTRY_W),
        .DEPTH(sinv_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign rd_key = ram_rdata[sinv_pkg::ENTRY_W-1 -: sinv_pkg::KEY_W];
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = upper_reg ? (rd_key <= target_reg) : (rd_key < target_reg);
    assign d_hi   = {khi_reg[sinv_pkg::KEY_W-1], khi_reg}
                    - {cmd_reg.key_value[sinv_pkg::KEY_W-1], cmd_reg.key_value};
    assign d_lo   = {cmd_reg.key_value[sinv_pkg::KEY_W-1], cmd_reg.key_value}
                    - {rd_key[sinv_pkg::KEY_W-1], rd_key};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sinv_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        srch_reg   <= srch_next;
        cmd_reg    <= cmd_next;
        rsp_reg    <= rsp_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        target_reg <= target_next;
        khi_reg    <= khi_next;
        upper_reg  <= upper_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sinv_pkg::ST_IDLE:
            begin
                // hold while the previous result is still on the ports
                if (start && !done_reg)
                begin
                    if (cmd.func == sinv_pkg::FUNC_INSERT)
                    begin
                        state_next = (count_reg == CW'(sinv_pkg::TABLE_DEPTH))
                                     ? sinv_pkg::ST_DONE : sinv_pkg::ST_LB_RD;
                    end
                    else
                    begin
                        state_next = (count_reg == '0)
                                     ? sinv_pkg::ST_DONE : sinv_pkg::ST_LB_RD;
                    end
                end
            end
            sinv_pkg::ST_LB_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = sinv_pkg::ST_LB_CMP;
                end
                else
                begin
                    case (srch_reg)
                        sinv_pkg::SRCH_INSERT:
                            state_next = (lo_reg == count_reg)
                                         ? sinv_pkg::ST_INS_WR : sinv_pkg::ST_SH_RD;
                        sinv_pkg::SRCH_QUERY:
                            state_next = sinv_pkg::ST_Q_RD1;
                        default:
                            state_next = sinv_pkg::ST_FETCH;
                    endcase
                end
            end
            sinv_pkg::ST_LB_CMP: state_next = sinv_pkg::ST_LB_RD;
            sinv_pkg::ST_Q_RD1:
            begin
                if (idx_reg == count_reg)
                    state_next = sinv_pkg::ST_Q_PICK;
                else if (idx_reg == '0)
                    state_next = sinv_pkg::ST_FETCH;
                else
                    state_next = sinv_pkg::ST_Q_RD0;
            end
            sinv_pkg::ST_Q_RD0:  state_next = sinv_pkg::ST_Q_PICK;
            sinv_pkg::ST_Q_PICK:
            begin
                if (idx_reg != count_reg && d_hi < d_lo)
                    state_next = sinv_pkg::ST_FETCH;
                else
                    state_next = sinv_pkg::ST_LB_RD;
            end
            sinv_pkg::ST_FETCH:   state_next = sinv_pkg::ST_FETCH_W;
            sinv_pkg::ST_FETCH_W: state_next = sinv_pkg::ST_IDLE;
            sinv_pkg::ST_SH_RD:   state_next = sinv_pkg::ST_SH_WR;
            sinv_pkg::ST_SH_WR:
                state_next = (idx_reg - CW'(1) == lo_reg)
                             ? sinv_pkg::ST_INS_WR : sinv_pkg::ST_SH_RD;
            sinv_pkg::ST_INS_WR:  state_next = sinv_pkg::ST_IDLE;
            sinv_pkg::ST_DONE:    state_next = sinv_pkg::ST_IDLE;
            default:              state_next = sinv_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        srch_next   = srch_reg;
        cmd_next    = cmd_reg;
        rsp_next    = rsp_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        target_next = target_reg;
        khi_next    = khi_reg;
        upper_next  = upper_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = mid[AW-1:0];
        ram_wdata   = {cmd_reg.key_value, cmd_reg.record_tag};
        case (state_reg)
            sinv_pkg::ST_IDLE:
            begin
                cmd_next    = cmd;
                lo_next     = '0;
                hi_next     = count_reg;
                target_next = cmd.key_value;
                upper_next  = (cmd.func == sinv_pkg::FUNC_INSERT);
                srch_next   = (cmd.func == sinv_pkg::FUNC_INSERT)
                              ? sinv_pkg::SRCH_INSERT : sinv_pkg::SRCH_QUERY;
                rsp_next    = '0;
                if (cmd.func == sinv_pkg::FUNC_INSERT)
                    rsp_next.status = (count_reg == CW'(sinv_pkg::TABLE_DEPTH))
                                      ? sinv_pkg::STATUS_FULL : sinv_pkg::STATUS_INSERTED;
                else
                    rsp_next.status = (count_reg == '0)
                                      ? sinv_pkg::STATUS_EMPTY : sinv_pkg::STATUS_FOUND;
            end
            sinv_pkg::ST_LB_RD:
            begin
                idx_next = lo_reg;
                if (lo_reg >= hi_reg)
                begin
                    // search result sits in lo
                    if (srch_reg == sinv_pkg::SRCH_INSERT)
                        idx_next = count_reg;
                    else if (srch_reg == sinv_pkg::SRCH_DUP)
                        idx_next = lo_reg;
                    hi_next = lo_reg;
                end
            end
            sinv_pkg::ST_LB_CMP:
            begin
                if (go_right)
                    lo_next = mid + CW'(1);
                else
                    hi_next = mid;
            end
            sinv_pkg::ST_Q_RD1:
            begin
                if (idx_reg == count_reg)
                    ram_addr = AW'(count_reg - CW'(1));
                else
                    ram_addr = idx_reg[AW-1:0];
            end
            sinv_pkg::ST_Q_RD0:
            begin
                khi_next = rd_key;
                ram_addr = AW'(idx_reg - CW'(1));
            end
            sinv_pkg::ST_Q_PICK:
            begin
                // rd_key holds entry idx-1 (or the last entry)
                lo_next     = '0;
                hi_next     = count_reg;
                target_next = rd_key;
                upper_next  = 1'b0;
                srch_next   = sinv_pkg::SRCH_DUP;
            end
            sinv_pkg::ST_FETCH:
            begin
                ram_addr = idx_reg[AW-1:0];
            end
            sinv_pkg::ST_FETCH_W:
            begin
                rsp_next.nearest_value = rd_key;
                rsp_next.nearest_tag   = ram_rdata[sinv_pkg::TAG_W-1:0];
                done_next              = 1'b1;
            end
            sinv_pkg::ST_SH_RD:
            begin
                ram_addr = AW'(idx_reg - CW'(1));
            end
            sinv_pkg::ST_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_reg - CW'(1);
            end
            sinv_pkg::ST_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_addr   = lo_reg[AW-1:0];
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
            end
            sinv_pkg::ST_DONE:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign busy   = (state_reg != sinv_pkg::ST_IDLE) || done_reg;
    assign done   = done_reg;
    assign result = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(sinv_pkg::TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)
        && done_reg && rsp_reg.status == sinv_pkg::STATUS_INSERTED))
        else $error("entry count moved without a successful insert");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != sinv_pkg::ST_IDLE)
        else $error("result without a command in flight");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == sinv_pkg::STATUS_EMPTY) |->
        (count_reg == '0))
        else $error("empty status with entries stored");

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives insert and query commands into the sorted key table, predicts each
// answer from a software copy of the table, and checks every result in order.
// ----------------------------------------------------------------------------

class table_scoreboard;
    logic signed [sinv_pkg::KEY_W-1:0] keys [sinv_pkg::TABLE_DEPTH];
    logic [sinv_pkg::TAG_W-1:0]        tags [sinv_pkg::TABLE_DEPTH];
    int                                entries;
    sinv_pkg::rsp_t                    answers [$];
    int                                mismatches;

    function new();
        entries    = 0;
        mismatches = 0;
    endfunction

    // first position whose key is >= v, or > v when after_equal is set
    function int bound(longint v, bit after_equal);
        int i;
        for (i = 0; i < entries; i++)
        begin
            if (after_equal ? (longint'(keys[i]) > v) : (longint'(keys[i]) >= v))
                return i;
        end
        return entries;
    endfunction

    function void note_command(sinv_pkg::cmd_t c);
        sinv_pkg::rsp_t r;
        int     pos;
        int     pick;
        longint v;
        longint d_hi;
        longint d_lo;
        r = '0;
        v = longint'(c.key_value);
        if (c.func == sinv_pkg::FUNC_INSERT)
        begin
            if (entries >= sinv_pkg::TABLE_DEPTH)
                r.status = sinv_pkg::STATUS_FULL;
            else
            begin
                pos = bound(v, 1'b1);
                for (int i = entries; i > pos; i--)
                begin
                    keys[i] = keys[i-1];
                    tags[i] = tags[i-1];
                end
                keys[pos] = c.key_value;
                tags[pos] = c.record_tag;
                entries++;
                r.status = sinv_pkg::STATUS_INSERTED;
            end
        end
        else if (entries == 0)
            r.status = sinv_pkg::STATUS_EMPTY;
        else
        begin
            pos = bound(v, 1'b0);
            if (pos >= entries)
                pick = bound(longint'(keys[entries-1]), 1'b0);
            else if (pos == 0)
                pick = 0;
            else
            begin
                d_hi = longint'(keys[pos]) - v;
                d_lo = v - longint'(keys[pos-1]);
                // equal distance goes to the smaller key, earliest duplicate
                pick = (d_hi < d_lo) ? pos : bound(longint'(keys[pos-1]), 1'b0);
            end
            r.status        = sinv_pkg::STATUS_FOUND;
            r.nearest_value = keys[pick];
            r.nearest_tag   = tags[pick];
        end
        answers.push_back(r);
    endfunction

    function void check_result(sinv_pkg::rsp_t got);
        sinv_pkg::rsp_t want;
        if (answers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status %0d value %0d tag %0d",
                         got.status, got.nearest_value, got.nearest_tag);
            return;
        end
        want = answers.pop_front();
        if (got.status !== want.status || got.nearest_value !== want.nearest_value ||
            got.nearest_tag !== want.nearest_tag)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected status %0d value %0d tag %0d, got %0d %0d %0d",
                         want.status, want.nearest_value, want.nearest_tag,
                         got.status, got.nearest_value, got.nearest_tag);
        end
    endfunction

    function int pending();
        return answers.size();
    endfunction
endclass

module testbench;
    localparam int STALL_LIMIT = 40000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE     = 32'sh0080_0000;

    logic           clk;
    logic           rst_n;
    logic           start;
    sinv_pkg::cmd_t cmd;
    logic           busy;
    logic           done;
    sinv_pkg::rsp_t result;

    table_scoreboard table_sb;
    int              idle_pct;
    int              quiet_cycles;

    sorted_index_nearest_value_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watch both sides of the block and keep the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                table_sb.note_command(cmd);
            if (done)
                table_sb.check_result(result);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic issue(logic f, logic signed [31:0] k, logic [9:0] t);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{func: f, key_value: k, record_tag: t};
        // hold until the transfer happens
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off();
        start <= 1'b0;
        @(posedge clk);
        while (table_sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
            return $urandom;
        if (sel < 35)
            return $urandom_range(1) ? KEY_MAX - $urandom_range(3) : KEY_MIN + $urandom_range(3);
        // small grid of whole numbers: duplicates and equal distances are frequent
        return ($signed($urandom_range(40)) - 20) * ONE;
    endfunction

    initial
    begin
        table_sb     = new();
        quiet_cycles = 0;
        idle_pct     = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed part
        issue(sinv_pkg::FUNC_QUERY, 32'sd0, 10'h3FF);
        issue(sinv_pkg::FUNC_INSERT, 2 * ONE, 10'd1);
        issue(sinv_pkg::FUNC_INSERT, 4 * ONE, 10'd2);
        issue(sinv_pkg::FUNC_QUERY, 3 * ONE, 10'd0);
        issue(sinv_pkg::FUNC_INSERT, 2 * ONE, 10'd3);
        issue(sinv_pkg::FUNC_INSERT, 4 * ONE, 10'd4);
        issue(sinv_pkg::FUNC_QUERY, 2 * ONE, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, 4 * ONE, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, 3 * ONE, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, KEY_MAX, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, KEY_MIN, 10'd0);
        issue(sinv_pkg::FUNC_INSERT, KEY_MAX, 10'h3FF);
        issue(sinv_pkg::FUNC_INSERT, KEY_MIN, 10'h000);
        issue(sinv_pkg::FUNC_INSERT, KEY_MIN, 10'h155);
        issue(sinv_pkg::FUNC_INSERT, 32'sd0, 10'h2AA);
        issue(sinv_pkg::FUNC_QUERY, KEY_MAX, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, KEY_MIN, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, 32'sd1, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, -32'sd1, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, 3 * ONE + 1, 10'd0);
        issue(sinv_pkg::FUNC_QUERY, KEY_MAX - 1, 10'd0);
        hold_off();

        // random part in idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 47 : (phase == 3) ? 27 : 0;
            for (int n = 0; n < 140; n++)
                issue($urandom_range(99) < 45, pick_key(), 10'($urandom));
            if (phase == 1)
                hold_off();
        end

        start <= 1'b0;
        @(posedge clk);
        while (table_sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (table_sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
